// ----- design/fpc_pkg.sv -----
// Shared types, register indexes, status codes and the CRC step for the frame parser.
`default_nettype none

package fpc_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_START_BYTE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLY     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CRC_INIT     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_TIMEOUT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ASM_TIMEOUT  = 3'd4;

    localparam logic [7:0]  START_BYTE_RST  = 8'hAA;
    localparam logic [15:0] CRC_POLY_RST    = 16'h1021;
    localparam logic [15:0] CRC_INIT_RST    = 16'hFFFF;
    localparam logic [15:0] GAP_TIMEOUT_RST = 16'd100;
    localparam logic [15:0] ASM_TIMEOUT_RST = 16'd1000;

    localparam logic [1:0] ST_PAYLOAD  = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_CRC_ERR  = 2'd2;
    localparam logic [1:0] ST_OVERSIZE = 2'd3;

    localparam logic [15:0] CRC_MSB = 16'h8000;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] now_ms;
    } fp_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] frame_seq;
        logic [7:0] frame_cmd;
        logic [7:0] frame_len;
        logic [5:0] byte_index;
        logic [7:0] payload_byte;
        logic       last;
    } fp_out_t;

    // MSB-first CRC-16 over one byte, no reflection
    function automatic logic [15:0] crc_fold(input logic [15:0] crc,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_MSB) != 16'h0000)
                c = {c[14:0], 1'b0} ^ poly;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/frame_parser_crc16_timeouts.sv -----
// Framed packet parser with CRC-16 check, byte and frame timeouts, payload buffer.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------
//  in      | in_valid/in_stall  | fp_in_t  (data_byte, now_ms)
//  out     | out_valid/out_stall| fp_out_t (status, seq, cmd, len, index, byte, last)
//  cfg     | cfg_write          | cfg_index, cfg_data
//
// One received byte is taken per cycle while in_stall is low. A good frame with payload is read back
// from the payload RAM, each result through a registered RAM read and then the
// output register; in_stall stays high for that readout.
// in_stall is also high while a finished result waits under out_stall.
// Reset clears the parser to idle and loads the register defaults; the payload
// RAM is not cleared.
`default_nettype none

module frame_parser_crc16_timeouts
    import fpc_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire fp_in_t                 in_data,

    output logic                        out_valid,
    input  wire logic                   out_stall,
    output fp_out_t                     out_data,

    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int DEPTH = 1 << AW;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_SEQ   = 3'd1;
    localparam logic [2:0] PH_CMD   = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_PAY   = 3'd4;
    localparam logic [2:0] PH_CRCLO = 3'd5;
    localparam logic [2:0] PH_CRCHI = 3'd6;

    // configuration
    logic [7:0]  start_byte_reg;
    logic [15:0] crc_poly_reg;
    logic [15:0] crc_init_reg;
    logic [15:0] gap_timeout_reg;
    logic [15:0] asm_timeout_reg;

    // parser state
    logic [2:0]  phase_reg,      phase_next;
    logic [7:0]  seq_reg,        seq_next;
    logic [7:0]  cmd_reg,        cmd_next;
    logic [7:0]  len_reg,        len_next;
    logic [6:0]  fill_reg,       fill_next;
    logic [15:0] crc_reg,        crc_next;
    logic [7:0]  crc_lo_reg,     crc_lo_next;
    logic [31:0] last_time_reg,  last_time_next;
    logic [31:0] start_time_reg, start_time_next;

    // readout
    logic          rd_active_reg, rd_active_next;
    logic          rd_ready_reg,  rd_ready_next;
    logic [AW-1:0] rd_addr_reg,   rd_addr_next;
    logic [AW-1:0] rd_last_reg,   rd_last_next;

    // output register
    logic    out_valid_reg, out_valid_next;
    fp_out_t out_reg,       out_next;

    // payload RAM
    logic [7:0]  mem [DEPTH];
    logic [7:0]  mem_q_reg;
    logic        mem_we;

    logic        in_accept;
    logic        out_free;
    logic        rd_load;
    logic        res_valid;
    fp_out_t     res;
    logic [2:0]  phase_eff;
    logic        gap_expired;
    logic        asm_expired;
    logic [15:0] crc_step;
    logic [7:0]  b;
    logic [31:0] now;
    logic [6:0]  fill_inc;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = rd_active_reg || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;
    assign rd_load   = rd_active_reg && rd_ready_reg && out_free;

    assign b        = in_data.data_byte;
    assign now      = in_data.now_ms;
    assign crc_step = crc_fold(crc_reg, b, crc_poly_reg);
    assign fill_inc = fill_reg + 7'd1;

    assign gap_expired = (phase_reg != PH_IDLE) && (last_time_reg != 32'h0)
                      && ((now - last_time_reg) > {16'h0000, gap_timeout_reg});
    assign asm_expired = (phase_reg != PH_IDLE) && (start_time_reg != 32'h0)
                      && ((now - start_time_reg) > {16'h0000, asm_timeout_reg});
    assign phase_eff   = (gap_expired || asm_expired) ? PH_IDLE : phase_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        seq_next        = seq_reg;
        cmd_next        = cmd_reg;
        len_next        = len_reg;
        fill_next       = fill_reg;
        crc_next        = crc_reg;
        crc_lo_next     = crc_lo_reg;
        last_time_next  = last_time_reg;
        start_time_next = start_time_reg;
        rd_active_next  = rd_active_reg;
        rd_addr_next    = rd_addr_reg;
        rd_last_next    = rd_last_reg;
        mem_we          = 1'b0;
        res_valid       = 1'b0;
        res             = '0;

        if (in_accept)
        begin
            last_time_next = now;
            case (phase_eff)
                PH_SEQ:
                begin
                    seq_next   = b;
                    crc_next   = crc_step;
                    phase_next = PH_CMD;
                end
                PH_CMD:
                begin
                    cmd_next   = b;
                    crc_next   = crc_step;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    len_next  = b;
                    crc_next  = crc_step;
                    fill_next = 7'd0;
                    if (b > 8'(MAX_PAYLOAD))
                    begin
                        res_valid     = 1'b1;
                        res.status    = ST_OVERSIZE;
                        res.frame_seq = seq_reg;
                        res.frame_cmd = cmd_reg;
                        res.frame_len = b;
                        res.last      = 1'b1;
                        phase_next    = PH_IDLE;
                    end
                    else if (b == 8'h00)
                        phase_next = PH_CRCLO;
                    else
                        phase_next = PH_PAY;
                end
                PH_PAY:
                begin
                    mem_we    = 1'b1;
                    fill_next = fill_inc;
                    crc_next  = crc_step;
                    if ({1'b0, fill_inc} >= len_reg)
                        phase_next = PH_CRCLO;
                end
                PH_CRCLO:
                begin
                    crc_lo_next = b;
                    phase_next  = PH_CRCHI;
                end
                PH_CRCHI:
                begin
                    phase_next    = PH_IDLE;
                    res.frame_seq = seq_reg;
                    res.frame_cmd = cmd_reg;
                    res.frame_len = len_reg;
                    res.last      = 1'b1;
                    if ({b, crc_lo_reg} != crc_reg)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_CRC_ERR;
                    end
                    else if (len_reg == 8'h00)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_EMPTY;
                    end
                    else
                    begin
                        // hand over to the RAM readout
                        rd_active_next = 1'b1;
                        rd_addr_next   = '0;
                        rd_last_next   = AW'(len_reg - 8'd1);
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (b == start_byte_reg)
                    begin
                        phase_next      = PH_SEQ;
                        crc_next        = crc_init_reg;
                        fill_next       = 7'd0;
                        start_time_next = now;
                    end
                end
            endcase
        end

        if (rd_load)
        begin
            res_valid        = 1'b1;
            res.status       = ST_PAYLOAD;
            res.frame_seq    = seq_reg;
            res.frame_cmd    = cmd_reg;
            res.frame_len    = len_reg;
            res.byte_index   = 6'(rd_addr_reg);
            res.payload_byte = mem_q_reg;
            res.last         = (rd_addr_reg == rd_last_reg);
            if (rd_addr_reg == rd_last_reg)
                rd_active_next = 1'b0;
            else
                rd_addr_next = rd_addr_reg + 1'b1;
        end

        // RAM data is good in the cycle after the address settles
        rd_ready_next = rd_active_reg && !rd_load && (rd_active_next == rd_active_reg);

        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg  <= START_BYTE_RST;
            crc_poly_reg    <= CRC_POLY_RST;
            crc_init_reg    <= CRC_INIT_RST;
            gap_timeout_reg <= GAP_TIMEOUT_RST;
            asm_timeout_reg <= ASM_TIMEOUT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_START_BYTE:  start_byte_reg  <= cfg_data[7:0];
                REG_CRC_POLY:    crc_poly_reg    <= cfg_data;
                REG_CRC_INIT:    crc_init_reg    <= cfg_data;
                REG_GAP_TIMEOUT: gap_timeout_reg <= cfg_data;
                REG_ASM_TIMEOUT: asm_timeout_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            seq_reg        <= 8'h00;
            cmd_reg        <= 8'h00;
            len_reg        <= 8'h00;
            fill_reg       <= 7'd0;
            crc_reg        <= CRC_INIT_RST;
            crc_lo_reg     <= 8'h00;
            last_time_reg  <= 32'h0;
            start_time_reg <= 32'h0;
            rd_active_reg  <= 1'b0;
            rd_ready_reg   <= 1'b0;
            rd_addr_reg    <= '0;
            rd_last_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            seq_reg        <= seq_next;
            cmd_reg        <= cmd_next;
            len_reg        <= len_next;
            fill_reg       <= fill_next;
            crc_reg        <= crc_next;
            crc_lo_reg     <= crc_lo_next;
            last_time_reg  <= last_time_next;
            start_time_reg <= start_time_next;
            rd_active_reg  <= rd_active_next;
            rd_ready_reg   <= rd_ready_next;
            rd_addr_reg    <= rd_addr_next;
            rd_last_reg    <= rd_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[fill_reg[AW-1:0]] <= b;
        mem_q_reg <= mem[rd_addr_reg];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire
